FILE: rtl/core/wmln_pkg.sv
// ----------------------------------------------------------------------------
// wmln_pkg
// Shared widths, constants and types of the window min/max level normalizer.
// ----------------------------------------------------------------------------
package wmln_pkg;

  localparam int WMLN_WINDOW = 32;

  localparam int SAMPLE_W = 8;
  localparam int LEVEL_W  = 7;
  localparam int COUNT_W  = 2;
  localparam int MASK_W   = 3;
  localparam int THR_W    = 7;
  localparam int NUM_W    = SAMPLE_W + LEVEL_W;
  localparam int STEP_W   = $clog2(LEVEL_W);

  localparam int PERCENT = 100;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_SECOND = 2'd1;
  localparam logic [1:0] REG_THIRD  = 2'd2;

  localparam logic [THR_W-1:0] FIRST_RST  = THR_W'(25);
  localparam logic [THR_W-1:0] SECOND_RST = THR_W'(50);
  localparam logic [THR_W-1:0] THIRD_RST  = THR_W'(75);

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
  } tok_t;

endpackage

FILE: rtl/core/wmln_in_if.sv
// ----------------------------------------------------------------------------
// wmln_in_if
// Sample request channel: valid/ready handshake with one level sample.
// ----------------------------------------------------------------------------
interface wmln_in_if;
  import wmln_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/wmln_out_if.sv
// ----------------------------------------------------------------------------
// wmln_out_if
// Result request channel: valid/ready handshake with level and led fields.
// ----------------------------------------------------------------------------
interface wmln_out_if;
  import wmln_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] relative_level;
  logic [COUNT_W-1:0] led_count;
  logic [MASK_W-1:0]  led_mask;

  modport source (output valid, output relative_level, output led_count,
                  output led_mask, input ready);
  modport sink   (input valid, input relative_level, input led_count,
                  input led_mask, output ready);
endinterface

FILE: rtl/core/wmln_cell.sv
// ----------------------------------------------------------------------------
// wmln_cell
// One window cell: holds a sample, shifts it on, and folds it into the
// min/max token that passes through.
// ----------------------------------------------------------------------------
module wmln_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift_en,
  input  logic [wmln_pkg::SAMPLE_W-1:0] shift_in,
  output logic [wmln_pkg::SAMPLE_W-1:0] value,
  input  wmln_pkg::tok_t                tok_in,
  output wmln_pkg::tok_t                tok_out
);
  import wmln_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      value         <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      if (shift_en) begin
        value <= shift_in;
      end
      tok_out.valid <= tok_in.valid;
    end
    tok_out.lo <= (value < tok_in.lo) ? value : tok_in.lo;
    tok_out.hi <= (value > tok_in.hi) ? value : tok_in.hi;
  end

endmodule

FILE: rtl/core/wmln_div.sv
// ----------------------------------------------------------------------------
// wmln_div
// Restoring divider, one quotient bit per cycle, for quotients below 2^7.
// ----------------------------------------------------------------------------
module wmln_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wmln_pkg::NUM_W-1:0]    num,
  input  logic [wmln_pkg::SAMPLE_W-1:0] den,
  output logic                          done,
  output logic [wmln_pkg::LEVEL_W-1:0]  quot
);
  import wmln_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [NUM_W-1:0]    rem;
  logic [SAMPLE_W-1:0] den_q;
  logic [NUM_W-1:0]    trial;

  assign trial = NUM_W'(den_q) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem   <= num;
      den_q <= den;
      quot  <= '0;
      step  <= STEP_W'(LEVEL_W - 1);
    end else if (busy) begin
      if (rem >= trial) begin
        rem        <= rem - trial;
        quot[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

endmodule

FILE: rtl/core/window_minmax_level_normalizer_unit.sv
// ----------------------------------------------------------------------------
// window_minmax_level_normalizer_unit
// Keeps the last WINDOW level samples, finds their minimum and maximum and
// returns the new sample's position between them in percent, with led count.
//
// samples : sink channel, one 8-bit level sample per request
// levels  : source channel, relative_level, led_count and led_mask
// apb     : three 7-bit thresholds at byte addresses 0, 4 and 8
//
// A sample shifts into a chain of WINDOW cells; a min/max token then walks
// the chain, one cell per cycle, followed by a restoring divide of
// (sample - min) * 100 by (max - min). The accepted sample starts the scan;
// once the token leaves the last cell the divide starts, and its quotient
// goes through S_HOLD into the output register. One sample is in work at a
// time, so no new request is taken until the result has left S_HOLD:
// samples.ready is high only while the unit is idle, and it stays high while
// a finished result waits in the output register. When the receiver stalls,
// a second finished result waits inside until the output register frees up.
// Reset empties the pipeline, clears every cell to zero (those zeros count
// in min/max until overwritten) and loads thresholds 25, 50 and 75.
// ----------------------------------------------------------------------------
module window_minmax_level_normalizer_unit #(
  parameter int WINDOW = wmln_pkg::WMLN_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  wmln_in_if.sink                         samples,
  wmln_out_if.source                      levels,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wmln_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wmln_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wmln_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import wmln_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_HOLD} state_t;

  state_t              state;
  logic [THR_W-1:0]    first_threshold;
  logic [THR_W-1:0]    second_threshold;
  logic [THR_W-1:0]    third_threshold;
  logic [SAMPLE_W-1:0] sample_q;
  logic                scan_start;
  logic                div_start;
  logic                div_done;
  logic [LEVEL_W-1:0]  div_quot;
  logic [NUM_W-1:0]    num;
  logic [SAMPLE_W-1:0] den;
  logic                flat;
  logic [LEVEL_W-1:0]  level;
  logic [COUNT_W-1:0]  count_next;
  logic [MASK_W-1:0]   mask_next;
  logic [SAMPLE_W-1:0] diff;
  logic                accept;
  logic                out_free;
  logic [1:0]          reg_index;
  tok_t                head;

  logic [SAMPLE_W-1:0] val [WINDOW];
  tok_t                tok [WINDOW];

  // cell chain
  assign head = '{valid: scan_start, lo: '1, hi: '0};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    wmln_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (accept),
      .shift_in ((i == 0) ? samples.sample : val[(i == 0) ? 0 : i - 1]),
      .value    (val[i]),
      .tok_in   ((i == 0) ? head : tok[(i == 0) ? 0 : i - 1]),
      .tok_out  (tok[i])
    );
  end

  wmln_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !levels.valid || levels.ready;
  assign diff          = sample_q - tok[WINDOW-1].lo;

  // threshold chain
  always_comb begin
    if (level < first_threshold) begin
      count_next = COUNT_W'(0);
    end else if (level < second_threshold) begin
      count_next = COUNT_W'(1);
    end else if (level < third_threshold) begin
      count_next = COUNT_W'(2);
    end else begin
      count_next = COUNT_W'(3);
    end
    case (count_next)
      2'd0:    mask_next = 3'b000;
      2'd1:    mask_next = 3'b001;
      2'd2:    mask_next = 3'b011;
      default: mask_next = 3'b111;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scan_start   <= 1'b0;
      div_start    <= 1'b0;
      levels.valid <= 1'b0;
    end else begin
      scan_start <= accept;
      div_start  <= 1'b0;
      if (levels.valid && levels.ready) begin
        levels.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok[WINDOW-1].valid) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            levels.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (accept) begin
      sample_q <= samples.sample;
    end
    if (state == S_SCAN && tok[WINDOW-1].valid) begin
      num  <= NUM_W'(diff) * NUM_W'(PERCENT);
      den  <= tok[WINDOW-1].hi - tok[WINDOW-1].lo;
      flat <= (tok[WINDOW-1].hi == tok[WINDOW-1].lo);
    end
    if (state == S_DIV && div_done) begin
      level <= flat ? '0 : div_quot;
    end
    if (state == S_HOLD && out_free) begin
      levels.relative_level <= level;
      levels.led_count      <= count_next;
      levels.led_mask       <= mask_next;
    end
  end

  // configuration port
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_threshold  <= FIRST_RST;
      second_threshold <= SECOND_RST;
      third_threshold  <= THIRD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        REG_FIRST:  first_threshold  <= pwdata[THR_W-1:0];
        REG_SECOND: second_threshold <= pwdata[THR_W-1:0];
        REG_THIRD:  third_threshold  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_FIRST:  prdata = APB_DATA_W'(first_threshold);
      REG_SECOND: prdata = APB_DATA_W'(second_threshold);
      REG_THIRD:  prdata = APB_DATA_W'(third_threshold);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/wmln_chk.sv
// ----------------------------------------------------------------------------
// wmln_chk
// Port-level checks of the level normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module wmln_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [wmln_pkg::LEVEL_W-1:0] relative_level,
  input logic [wmln_pkg::COUNT_W-1:0] led_count,
  input logic [wmln_pkg::MASK_W-1:0]  led_mask
);
  import wmln_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_no_quick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> relative_level <= LEVEL_W'(PERCENT))
    else $error("relative level above 100");

  a_mask_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> led_mask == MASK_W'((4'd1 << led_count) - 4'd1))
    else $error("led mask does not match led count");

endmodule

bind window_minmax_level_normalizer_unit wmln_chk u_wmln_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .out_valid      (levels.valid),
  .out_ready      (levels.ready),
  .relative_level (levels.relative_level),
  .led_count      (levels.led_count),
  .led_mask       (levels.led_mask)
);

FILE: tb/sv/window_minmax_level_normalizer_unit_test.sv
// ----------------------------------------------------------------------------
// window_minmax_level_normalizer_unit_test
// Sends level samples through the sample channel and predicts each result
// from a local copy of the sample ring and the thresholds. Results are checked
// field by field in order. Directed cases cover the cleared window, exact
// threshold edges and odd threshold settings. Random phases with random
// thresholds and stalls on both sides follow, plus a long receiver hold.
// ----------------------------------------------------------------------------
module window_minmax_level_normalizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wmln_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int LATENCY = WMLN_WINDOW + 11;
  localparam int PHASES = 11;
  localparam int PHASE_SAMPLES = 150;

  typedef struct packed {
    logic [LEVEL_W-1:0] relative_level;
    logic [COUNT_W-1:0] led_count;
    logic [MASK_W-1:0]  led_mask;
  } level_result_t;

  typedef enum int {PAT_UNIFORM, PAT_FLAT, PAT_BAND, PAT_EXTREME, PAT_RAMP} pattern_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  wmln_in_if  sample_ch ();
  wmln_out_if level_ch ();

  logic [SAMPLE_W-1:0] level_history [WMLN_WINDOW];
  int                  history_pos;
  logic [THR_W-1:0]    thresholds [3];
  level_result_t       pending_levels [$];

  int src_gap_max;
  int sink_stall_max;
  int sink_hold;
  int errors;

  window_minmax_level_normalizer_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .levels  (level_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("window_minmax_level_normalizer_unit test failed");
    $finish;
  end

  // ring update, window scan and threshold chain for one accepted sample
  task automatic normalize_sample(input logic [SAMPLE_W-1:0] s);
    int lo;
    int hi;
    int lvl;
    logic [COUNT_W-1:0] cnt;
    level_result_t r;
    level_history[history_pos] = s;
    history_pos = (history_pos + 1) % WMLN_WINDOW;
    lo = 255;
    hi = 0;
    foreach (level_history[i]) begin
      if (level_history[i] < lo) lo = level_history[i];
      if (level_history[i] > hi) hi = level_history[i];
    end
    lvl = (hi == lo) ? 0 : ((int'(s) - lo) * PERCENT) / (hi - lo);
    if (lvl < thresholds[REG_FIRST]) cnt = 2'd0;
    else if (lvl < thresholds[REG_SECOND]) cnt = 2'd1;
    else if (lvl < thresholds[REG_THIRD]) cnt = 2'd2;
    else cnt = 2'd3;
    r.relative_level = LEVEL_W'(lvl);
    r.led_count = cnt;
    r.led_mask = MASK_W'((1 << cnt) - 1);
    pending_levels.push_back(r);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    normalize_sample(s);
  endtask

  task automatic wait_levels_drained;
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_levels.size() != 0);
  endtask

  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_threshold(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] unused;
    apb_transfer(1'b1, idx, value, unused);
    if (idx <= REG_THIRD) thresholds[idx] = value[THR_W-1:0];
  endtask

  task automatic write_thresholds(input int t0, input int t1, input int t2);
    write_threshold(REG_FIRST, APB_DATA_W'(t0));
    write_threshold(REG_SECOND, APB_DATA_W'(t1));
    write_threshold(REG_THIRD, APB_DATA_W'(t2));
  endtask

  task automatic check_thresholds;
    logic [APB_DATA_W-1:0] got;
    logic [1:0] idx;
    for (int i = 0; i < 3; i++) begin
      idx = 2'(i);
      apb_transfer(1'b0, idx, '0, got);
      if (got !== APB_DATA_W'(thresholds[idx]))
        $error("threshold %0d: expected %0d, got %0d", i, thresholds[idx], got);
      if (got !== APB_DATA_W'(thresholds[idx])) errors++;
    end
  endtask

  // receiver: random stall per result, long hold on request
  initial begin
    int n;
    level_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      n = sink_hold + $urandom_range(0, sink_stall_max);
      sink_hold = 0;
      if (n > 0) begin
        level_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      level_ch.ready <= 1'b1;
      do @(posedge clk); while (!(level_ch.valid && level_ch.ready));
    end
  end

  always @(posedge clk) begin : check_levels
    level_result_t want;
    if (!rst && level_ch.valid && level_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected result: relative_level %0d", level_ch.relative_level);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (level_ch.relative_level !== want.relative_level) begin
          $error("relative_level: expected %0d, got %0d",
                 want.relative_level, level_ch.relative_level);
          errors++;
        end
        if (level_ch.led_count !== want.led_count) begin
          $error("led_count: expected %0d, got %0d", want.led_count, level_ch.led_count);
          errors++;
        end
        if (level_ch.led_mask !== want.led_mask) begin
          $error("led_mask: expected %0d, got %0d", want.led_mask, level_ch.led_mask);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_values;
    check_thresholds();
  endtask

  // zeros from reset still in the window, so lo = 0 and hi = 100 gives level = sample
  task automatic test_window_edges;
    send_sample(8'd0);
    send_sample(8'd100);
    send_sample(8'd24);
    send_sample(8'd25);
    send_sample(8'd49);
    send_sample(8'd50);
    send_sample(8'd74);
    send_sample(8'd75);
    send_sample(8'd99);
    send_sample(8'd255);
    send_sample(8'd128);
    send_sample(8'd1);
    wait_levels_drained();
  endtask

  task automatic test_threshold_settings;
    write_thresholds(0, 0, 0);
    send_sample(8'd0);
    send_sample(8'd255);
    wait_levels_drained();
    write_thresholds(127, 127, 127);
    send_sample(8'd255);
    send_sample(8'd0);
    wait_levels_drained();
    write_thresholds(100, 100, 100);
    send_sample(8'd255);
    send_sample(8'd254);
    wait_levels_drained();
    write_thresholds(90, 50, 10);
    send_sample(8'd128);
    send_sample(8'd240);
    wait_levels_drained();
    write_threshold(REG_NONE, 32'h0000_007f);
    write_threshold(REG_SECOND, 32'hffff_ffa8);
    check_thresholds();
    send_sample(8'd102);
    wait_levels_drained();
    write_thresholds(FIRST_RST, SECOND_RST, THIRD_RST);
  endtask

  task automatic test_backpressure;
    src_gap_max = 0;
    sink_stall_max = 0;
    sink_hold = 400;
    repeat (12) send_sample(SAMPLE_W'($urandom_range(0, 255)));
    wait_levels_drained();
    repeat (5) send_sample(SAMPLE_W'($urandom_range(0, 255)));
    wait_levels_drained();
    src_gap_max = 5;
    sink_stall_max = 5;
  endtask

  task automatic test_random_levels;
    int sent;
    int len;
    int base;
    int span;
    int t0;
    int t1;
    pattern_t kind;
    logic [SAMPLE_W-1:0] v;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_levels_drained();
      if ($urandom_range(0, 1)) begin
        t0 = $urandom_range(0, 100);
        t1 = $urandom_range(t0, 100);
        write_thresholds(t0, t1, $urandom_range(t1, 100));
      end else begin
        write_thresholds($urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 127));
      end
      src_gap_max = (phase % 3 == 0) ? 0 : 5;
      sink_stall_max = (phase % 4 == 1) ? 0 : 5;
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        kind = pattern_t'($urandom_range(PAT_UNIFORM, PAT_RAMP));
        len = (kind == PAT_FLAT) ? $urandom_range(33, 40) : $urandom_range(8, 40);
        base = $urandom_range(0, 255);
        span = $urandom_range(1, 4);
        for (int k = 0; k < len && sent < PHASE_SAMPLES; k++) begin
          case (kind)
            PAT_UNIFORM: v = SAMPLE_W'($urandom_range(0, 255));
            PAT_FLAT:    v = SAMPLE_W'(base);
            PAT_BAND:    v = SAMPLE_W'((base > 251 ? 251 : base) + $urandom_range(0, span));
            PAT_EXTREME: v = $urandom_range(0, 1) ? SAMPLE_W'(255 - $urandom_range(0, 2))
                                                  : SAMPLE_W'($urandom_range(0, 2));
            default:     v = SAMPLE_W'(base + k * span);
          endcase
          send_sample(v);
          sent++;
        end
      end
    end
    wait_levels_drained();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    src_gap_max = 5;
    sink_stall_max = 5;
    sink_hold = 0;
    errors = 0;
    foreach (level_history[i]) level_history[i] = '0;
    history_pos = 0;
    thresholds[REG_FIRST] = FIRST_RST;
    thresholds[REG_SECOND] = SECOND_RST;
    thresholds[REG_THIRD] = THIRD_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_window_edges();
    test_threshold_settings();
    test_backpressure();
    test_random_levels();

    wait_levels_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("window_minmax_level_normalizer_unit test passed");
    end else begin
      $display("window_minmax_level_normalizer_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/wmln_pkg.sv
rtl/core/wmln_in_if.sv
rtl/core/wmln_out_if.sv
rtl/core/wmln_cell.sv
rtl/core/wmln_div.sv
rtl/core/window_minmax_level_normalizer_unit.sv
rtl/core/wmln_chk.sv
tb/sv/window_minmax_level_normalizer_unit_test.sv
